### design/emm_pkg.sv
`timescale 1ns / 1ps

package emm_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_SHAPE = 2'd0,
        CMD_LOAD_POINT = 2'd1,
        CMD_COMPUTE    = 2'd2
    } t_cmd;

    localparam logic [1:0] REG_NUM_SHAPE  = 2'd0;
    localparam logic [1:0] REG_NUM_POINTS = 2'd1;
    localparam logic [1:0] REG_DIFF_COEFF = 2'd2;

    localparam logic [6:0]  NUM_SHAPE_RESET  = 7'd1;
    localparam logic [8:0]  NUM_POINTS_RESET = 9'd1;
    localparam logic [31:0] DIFF_COEFF_RESET = 32'h0001_0000;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // Q32.32 to Q16.16, floor, saturate to 32 bits
    function automatic logic signed [31:0] f_sat32_q16(input logic signed [63:0] v);
        logic signed [63:0] s;
        begin
            s = v >>> 16;
            if ((&s[63:31]) || (~|s[63:31])) begin
                return s[31:0];
            end else if (s[63]) begin
                return S32_MIN;
            end else begin
                return S32_MAX;
            end
        end
    endfunction

    // hi * 2^16 + lo, saturated to 64 bits
    function automatic logic signed [63:0] f_sat_term(input logic signed [63:0] hi,
                                                      input logic signed [48:0] lo);
        logic [80:0] full;
        begin
            full = ({{17{hi[63]}}, hi} << 16) + {{32{lo[48]}}, lo};
            if ((&full[80:63]) || (~|full[80:63])) begin
                return full[63:0];
            end else if (full[80]) begin
                return S64_MIN;
            end else begin
                return S64_MAX;
            end
        end
    endfunction

    function automatic logic signed [63:0] f_sat_add64(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] == s[63]) begin
                return s[63:0];
            end else if (s[64]) begin
                return S64_MIN;
            end else begin
                return S64_MAX;
            end
        end
    endfunction

endpackage

### design/emm_ram.sv
`timescale 1ns / 1ps

module emm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### design/element_mass_matrix_bdbt_unit.sv
`timescale 1ns / 1ps

// Mass matrix M = B * D * B^T, Q16.16 operands, Q32.32 saturated results.
// Input channel (i_valid / o_stall): one word carries a command. A shape load writes
// B(shape, point) in its accept cycle and is ready for the next word in the next cycle.
// A point load forms D(point) = weight * |det| * coefficient through two multiplies in
// PT_MUL and PT_SCALE and writes it in PT_WRITE. A compute word for row i emits row i
// on the output channel (o_valid / i_stall), columns 0 upward, o_last on the final
// column. Each column walks the stored points through one multiply-accumulate pipeline
// fed by the two read ports of the shape memory and the point-scale memory: points are
// issued in ROW_RUN, read, multiplied by D, multiplied in halves by B(col, point),
// joined into a term and accumulated; ROW_WAIT then moves the result to the output
// register. A finished entry waits in the output register; the next column is computed
// meanwhile, and its result is held in the accumulator while the receiver stalls.
// The input channel stalls until the row's last entry has been loaded into the output
// register. Reset clears the control state and restores the registers; both memories
// hold unknown data until written. The user must see that registers are written over
// the APB port while idle; the block itself leaves this unenforced.
module element_mass_matrix_bdbt_unit #(
    parameter int MAX_SHAPE  = 64,
    parameter int MAX_POINTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_command,
    input  logic [5:0]         i_shape_index,
    input  logic [7:0]         i_point_index,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_jac_det,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_row,
    output logic [5:0]         o_col,
    output logic signed [63:0] o_entry,
    output logic               o_last
);

    localparam int SA    = (MAX_SHAPE > 1) ? $clog2(MAX_SHAPE) : 1;
    localparam int PA    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SDEPTH = MAX_SHAPE * MAX_POINTS;
    localparam int SAW   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PT_MUL,
        ST_PT_SCALE,
        ST_PT_WRITE,
        ST_ROW_RUN,
        ST_ROW_WAIT
    } t_state;

    t_state r_state;

    logic [6:0]         r_num_shape;
    logic [8:0]         r_num_points;
    logic signed [31:0] r_diffusion_coeff;

    logic [SA-1:0] ns_last;
    logic [PA-1:0] np_last;

    logic [5:0]    r_row;
    logic [SA-1:0] r_col;
    logic [PA-1:0] r_k;
    logic          r_acc_done;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic               r_first1, r_first2, r_first3, r_first4;
    logic               r_last1, r_last2, r_last3, r_last4;
    logic signed [31:0] r_bj2;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_ph;
    logic signed [48:0] r_pl;
    logic signed [63:0] r_term;
    logic signed [63:0] r_acc;

    logic signed [31:0] r_val;
    logic signed [31:0] r_det;
    logic [PA-1:0]      r_pidx;
    logic signed [63:0] r_prod;

    logic               accept;
    logic               cfg_wr;
    logic               out_free;
    logic               out_load;
    logic               issue;
    logic               shape_ok;
    logic               point_ok;
    logic               sh_we;
    logic [SAW-1:0]     sh_waddr;
    logic [SAW-1:0]     sh_raddr_a;
    logic [SAW-1:0]     sh_raddr_b;
    logic signed [31:0] sh_rd_a;
    logic signed [31:0] sh_rd_b;
    logic               pt_we;
    logic signed [31:0] pt_wdata;
    logic signed [31:0] pt_rd;
    logic signed [32:0] det_ext;
    logic signed [32:0] det_abs;
    logic signed [31:0] t_scale;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign o_stall  = (r_state != ST_IDLE);
    assign accept   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;
    assign out_load = (r_state == ST_ROW_WAIT) && r_acc_done && out_free;
    assign issue    = (r_state == ST_ROW_RUN);

    assign shape_ok = (int'(i_shape_index) < MAX_SHAPE) && (int'(i_point_index) < MAX_POINTS);
    assign point_ok = (int'(i_point_index) < MAX_POINTS);

    always_comb begin
        if (r_num_shape == 7'd0) begin
            ns_last = '0;
        end else if (int'(r_num_shape) > MAX_SHAPE) begin
            ns_last = SA'(MAX_SHAPE - 1);
        end else begin
            ns_last = SA'(r_num_shape - 7'd1);
        end
        if (r_num_points == 9'd0) begin
            np_last = '0;
        end else if (int'(r_num_points) > MAX_POINTS) begin
            np_last = PA'(MAX_POINTS - 1);
        end else begin
            np_last = PA'(r_num_points - 9'd1);
        end
    end

    always_comb begin
        case (paddr[3:2])
            emm_pkg::REG_NUM_SHAPE:  prdata = {25'd0, r_num_shape};
            emm_pkg::REG_NUM_POINTS: prdata = {23'd0, r_num_points};
            emm_pkg::REG_DIFF_COEFF: prdata = r_diffusion_coeff;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_shape       <= emm_pkg::NUM_SHAPE_RESET;
            r_num_points      <= emm_pkg::NUM_POINTS_RESET;
            r_diffusion_coeff <= emm_pkg::DIFF_COEFF_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                emm_pkg::REG_NUM_SHAPE:  r_num_shape       <= pwdata[6:0];
                emm_pkg::REG_NUM_POINTS: r_num_points      <= pwdata[8:0];
                emm_pkg::REG_DIFF_COEFF: r_diffusion_coeff <= pwdata;
                default: ;
            endcase
        end
    end

    // memories
    assign sh_we      = accept && (emm_pkg::t_cmd'(i_command) == emm_pkg::CMD_LOAD_SHAPE)
                        && shape_ok;
    assign sh_waddr   = SAW'(i_shape_index) * SAW'(MAX_POINTS) + SAW'(i_point_index);
    assign sh_raddr_a = SAW'(r_row) * SAW'(MAX_POINTS) + SAW'(r_k);
    assign sh_raddr_b = SAW'(r_col) * SAW'(MAX_POINTS) + SAW'(r_k);

    emm_ram #(
        .WIDTH (32),
        .DEPTH (SDEPTH)
    ) u_shape_ram (
        .i_clk     (i_clk),
        .i_we      (sh_we),
        .i_waddr   (sh_waddr),
        .i_wdata   (i_value),
        .i_raddr_a (sh_raddr_a),
        .i_raddr_b (sh_raddr_b),
        .o_rdata_a (sh_rd_a),
        .o_rdata_b (sh_rd_b)
    );

    assign pt_we    = (r_state == ST_PT_WRITE);
    assign pt_wdata = emm_pkg::f_sat32_q16(r_prod);

    emm_ram #(
        .WIDTH (32),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .i_clk     (i_clk),
        .i_we      (pt_we),
        .i_waddr   (r_pidx),
        .i_wdata   (pt_wdata),
        .i_raddr_a (r_k),
        .i_raddr_b (r_k),
        .o_rdata_a (pt_rd),
        .o_rdata_b ()
    );

    // point scale datapath
    assign det_ext = $signed({r_det[31], r_det});
    assign det_abs = (det_ext < 0) ? -det_ext : det_ext;
    assign t_scale = emm_pkg::f_sat32_q16(r_prod);

    always_ff @(posedge i_clk) begin
        if (accept && (emm_pkg::t_cmd'(i_command) == emm_pkg::CMD_LOAD_POINT)) begin
            r_val  <= i_value;
            r_det  <= i_jac_det;
            r_pidx <= PA'(i_point_index);
        end
        case (r_state)
            ST_PT_MUL:   r_prod <= r_val * det_abs;
            ST_PT_SCALE: r_prod <= t_scale * r_diffusion_coeff;
            default: ;
        endcase
    end

    // multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_k == '0);
        r_last1  <= (r_k == np_last);
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_p1     <= sh_rd_a * pt_rd;
        r_bj2    <= sh_rd_b;
        r_first3 <= r_first2;
        r_last3  <= r_last2;
        r_ph     <= $signed(r_p1[63:32]) * r_bj2;
        r_pl     <= $signed({1'b0, r_p1[31:16]}) * r_bj2;
        r_first4 <= r_first3;
        r_last4  <= r_last3;
        r_term   <= emm_pkg::f_sat_term(r_ph, r_pl);
        if (r_v4) begin
            r_acc <= r_first4 ? r_term : emm_pkg::f_sat_add64(r_acc, r_term);
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_acc_done <= 1'b0;
            o_valid    <= 1'b0;
            r_k        <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (r_v4 && r_last4) begin
                r_acc_done <= 1'b1;
            end else if (out_load) begin
                r_acc_done <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (emm_pkg::t_cmd'(i_command))
                            emm_pkg::CMD_LOAD_POINT: begin
                                if (point_ok) begin
                                    r_state <= ST_PT_MUL;
                                end
                            end
                            emm_pkg::CMD_COMPUTE: begin
                                if (int'(i_shape_index) <= int'(ns_last)) begin
                                    r_row   <= i_shape_index;
                                    r_col   <= '0;
                                    r_k     <= '0;
                                    r_state <= ST_ROW_RUN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PT_MUL:   r_state <= ST_PT_SCALE;
                ST_PT_SCALE: r_state <= ST_PT_WRITE;
                ST_PT_WRITE: r_state <= ST_IDLE;
                ST_ROW_RUN: begin
                    if (r_k == np_last) begin
                        r_k     <= '0;
                        r_state <= ST_ROW_WAIT;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_ROW_WAIT: begin
                    if (out_load) begin
                        o_row      <= r_row;
                        o_col      <= 6'(r_col);
                        o_entry    <= r_acc;
                        o_last     <= (r_col == ns_last);
                        if (r_col == ns_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= ST_ROW_RUN;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_pipe_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_state == ST_ROW_RUN || r_state == ST_ROW_WAIT))
        else $error("accumulate stage active outside a row");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_done |-> (r_state == ST_ROW_WAIT))
        else $error("column result pending outside wait");

    a_drain_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW_WAIT && !r_v1 && !r_v2 && !r_v3 && !r_v4) |-> r_acc_done)
        else $error("pipeline drained without a column result");

endmodule
